### rtl/plt_pkg.sv
// Shared request codes, field widths and sequencer states for the positional list table.
package plt_pkg;

  // Field widths of the request and response payloads
  localparam int unsigned KIND_W = 2;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned VAL_W  = 32;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOCATE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd3;

  // Sequencer states
  localparam int unsigned STATE_W = 3;
  localparam logic [STATE_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [STATE_W-1:0] ST_READ   = 3'd1;
  localparam logic [STATE_W-1:0] ST_LOCATE = 3'd2;
  localparam logic [STATE_W-1:0] ST_INSERT = 3'd3;
  localparam logic [STATE_W-1:0] ST_DELETE = 3'd4;
  localparam logic [STATE_W-1:0] ST_DONE   = 3'd5;

endpackage

### rtl/plt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module plt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry, register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/positional_list_table.sv
// Top level of the positional list table: request sequencer around one element RAM.
//
// A fixed-capacity ordered list kept in a RAM of CAPACITY entries plus a length
// counter. A request (kind, position, value) enters on the in channel when
// in_valid_i is high and in_stall_o is low; one response (status,
// found_position, read_value, list_length) leaves on the out channel when
// out_valid_o is high and out_stall_i is low.
// One request is worked on at a time; in_stall_o is high from acceptance until
// the response has been loaded into the output register. The RAM handles one
// element per cycle. Per kind, the sequencer works as follows:
//   read            one RAM read at position p, then the data is taken
//   locate          scan upward from position 1 to the first hit or the end
//   insert at p     shift the tail up from the end, then write the new value
//   delete at p     shift the tail down over the removed slot
// Rejected requests go straight to the completion state. The response
// register frees the sequencer: a new request may enter while the previous
// response waits. If the receiver stalls, the response holds and a finished
// request waits in its last state.
// Reset clears the length; the RAM is not cleared, only entries below the length are read.
module positional_list_table #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [plt_pkg::KIND_W-1:0]      kind_i,
  input  logic [plt_pkg::POS_W-1:0]       position_i,
  input  logic signed [plt_pkg::VAL_W-1:0] value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            status_o,
  output logic [plt_pkg::POS_W-1:0]       found_position_o,
  output logic signed [plt_pkg::VAL_W-1:0] read_value_o,
  output logic [plt_pkg::POS_W-1:0]       list_length_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW >= plt_pkg::POS_W) ? CW + 1 : plt_pkg::POS_W + 1;
  localparam int unsigned EW = ELEMENT_WIDTH;

  logic [plt_pkg::STATE_W-1:0] state_q, state_d;
  logic [CW-1:0]               count_q, count_d;
  logic [CW-1:0]               idx_q, idx_d;
  logic [CW-1:0]               pidx_q, pidx_d;
  logic [CW-1:0]               pos_q, pos_d;
  logic                        pend_q, pend_d;
  logic [EW-1:0]               val_q, val_d;
  logic                        res_status_q, res_status_d;
  logic [plt_pkg::POS_W-1:0]   res_found_q, res_found_d;
  logic [plt_pkg::VAL_W-1:0]   res_read_q, res_read_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_status_q, out_status_d;
  logic [plt_pkg::POS_W-1:0]   out_found_q, out_found_d;
  logic [plt_pkg::VAL_W-1:0]   out_read_q, out_read_d;
  logic [plt_pkg::POS_W-1:0]   out_len_q, out_len_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic          in_acc;
  logic          issue;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic          rd_ok;
  logic          ins_ok;
  logic [63:0]   val_sx;
  logic [63:0]   rd_sx;

  plt_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Request checks against the current length
  assign in_stall_o = (state_q != plt_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pos_x      = XW'(position_i);
  assign cnt_x      = XW'(count_q);
  assign rd_ok      = (pos_x != '0) && (pos_x <= cnt_x);
  assign ins_ok     = (pos_x != '0) && (pos_x <= cnt_x + 1'b1) &&
                      (count_q != CW'(CAPACITY));
  assign val_sx     = 64'($signed(value_i));
  assign rd_sx      = 64'($signed(ram_rdata));

  // Sequencer: one RAM read and at most one RAM write per cycle
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    pidx_d       = pidx_q;
    pos_d        = pos_q;
    pend_d       = pend_q;
    val_d        = val_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_read_d   = res_read_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_read_d   = out_read_q;
    out_len_d    = out_len_q;
    ram_we       = 1'b0;
    ram_waddr    = pidx_q[AW-1:0];
    ram_wdata    = ram_rdata;
    ram_raddr    = idx_q[AW-1:0];
    issue        = 1'b0;

    // Drop the response once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      plt_pkg::ST_IDLE: begin
        if (in_acc) begin
          res_status_d = 1'b1;
          res_found_d  = '0;
          res_read_d   = '0;
          pend_d       = 1'b0;
          val_d        = val_sx[EW-1:0];
          unique case (kind_i)
            plt_pkg::KIND_READ: begin
              if (rd_ok) begin
                idx_d   = CW'(pos_x - 1'b1);
                state_d = plt_pkg::ST_READ;
              end else begin
                state_d = plt_pkg::ST_DONE;
              end
            end
            plt_pkg::KIND_LOCATE: begin
              idx_d   = '0;
              state_d = plt_pkg::ST_LOCATE;
            end
            plt_pkg::KIND_INSERT: begin
              if (ins_ok) begin
                idx_d   = count_q;
                pos_d   = CW'(pos_x);
                state_d = plt_pkg::ST_INSERT;
              end else begin
                state_d = plt_pkg::ST_DONE;
              end
            end
            plt_pkg::KIND_DELETE: begin
              if (rd_ok) begin
                idx_d   = CW'(pos_x);
                state_d = plt_pkg::ST_DELETE;
              end else begin
                state_d = plt_pkg::ST_DONE;
              end
            end
            default: begin
              state_d = plt_pkg::ST_DONE;
            end
          endcase
        end
      end

      // Issue one read, then take the data
      plt_pkg::ST_READ: begin
        if (!pend_q) begin
          pend_d = 1'b1;
        end else begin
          pend_d       = 1'b0;
          res_status_d = 1'b0;
          res_read_d   = rd_sx[plt_pkg::VAL_W-1:0];
          state_d      = plt_pkg::ST_DONE;
        end
      end

      // Scan upward, compare the element read in the previous cycle
      plt_pkg::ST_LOCATE: begin
        issue  = (idx_q < count_q);
        pend_d = issue;
        pidx_d = idx_q;
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end
        if (pend_q && (ram_rdata == val_q)) begin
          pend_d       = 1'b0;
          res_status_d = 1'b0;
          res_found_d  = plt_pkg::POS_W'(pidx_q + 1'b1);
          state_d      = plt_pkg::ST_DONE;
        end else if (!issue) begin
          pend_d  = 1'b0;
          state_d = plt_pkg::ST_DONE;
        end
      end

      // Shift the tail up from the end, then write the new value
      plt_pkg::ST_INSERT: begin
        issue     = (idx_q >= pos_q);
        ram_raddr = AW'(idx_q - 1'b1);
        pend_d    = issue;
        pidx_d    = idx_q;
        if (issue) begin
          idx_d = idx_q - 1'b1;
        end
        if (pend_q) begin
          ram_we = 1'b1;
        end else if (!issue) begin
          ram_we       = 1'b1;
          ram_waddr    = AW'(pos_q - 1'b1);
          ram_wdata    = val_q;
          count_d      = count_q + 1'b1;
          res_status_d = 1'b0;
          state_d      = plt_pkg::ST_DONE;
        end
      end

      // Shift the tail down over the removed slot
      plt_pkg::ST_DELETE: begin
        issue  = (idx_q < count_q);
        pend_d = issue;
        pidx_d = idx_q;
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(pidx_q - 1'b1);
        end else if (!issue) begin
          count_d      = count_q - 1'b1;
          res_status_d = 1'b0;
          state_d      = plt_pkg::ST_DONE;
        end
      end

      // Load the response register when it is free
      plt_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          out_read_d   = res_read_q;
          out_len_d    = plt_pkg::POS_W'(count_q);
          state_d      = plt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = plt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plt_pkg::ST_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    pidx_q       <= pidx_d;
    pos_q        <= pos_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_read_q   <= res_read_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_read_q   <= out_read_d;
    out_len_q    <= out_len_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_position_o = out_found_q;
  assign read_value_o     = out_read_q;
  assign list_length_o    = out_len_q;

  // Length never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("list length above capacity");

  // RAM writes only happen in the insert and delete states
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == plt_pkg::ST_INSERT || state_q == plt_pkg::ST_DELETE))
    else $error("RAM write outside insert or delete");

  // Writes stay inside the live list (one past the end while inserting)
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CW'(ram_waddr) <= count_q))
    else $error("RAM write beyond list end");

  // A new response only comes from the completion state
  a_resp_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == plt_pkg::ST_DONE)
    else $error("response raised outside completion");

  // Length only changes after an insert or delete state
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ($past(state_q) == plt_pkg::ST_INSERT || $past(state_q) == plt_pkg::ST_DELETE))
    else $error("length changed outside insert or delete");

endmodule

### bench/plt_checker.sv
// Response checker for the positional list table: tracks the list and compares every response.
module plt_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [plt_pkg::KIND_W-1:0]       kind_i,
  input  logic [plt_pkg::POS_W-1:0]        position_i,
  input  logic signed [plt_pkg::VAL_W-1:0] value_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic                             status_i,
  input  logic [plt_pkg::POS_W-1:0]        found_position_i,
  input  logic signed [plt_pkg::VAL_W-1:0] read_value_i,
  input  logic [plt_pkg::POS_W-1:0]        list_length_i,
  output int                               errors_o,
  output int                               outstanding_o,
  output int                               checked_o,
  output int                               peak_length_o,
  output int                               full_rejects_o
);

  typedef struct packed {
    logic                             status;
    logic [plt_pkg::POS_W-1:0]        found_position;
    logic signed [plt_pkg::VAL_W-1:0] read_value;
    logic [plt_pkg::POS_W-1:0]        list_length;
  } list_resp_t;

  // Shadow copy of the list contents and length
  logic signed [plt_pkg::VAL_W-1:0] shadow_list [CAPACITY];
  int                               shadow_len;
  list_resp_t                       expected_resp [$];

  int mismatches;
  int outstanding;
  int checked;
  int peak_len;
  int full_rejects;

  assign errors_o       = mismatches;
  assign outstanding_o  = outstanding;
  assign checked_o      = checked;
  assign peak_length_o  = peak_len;
  assign full_rejects_o = full_rejects;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Apply one request to the shadow list and queue the response it should give
  task automatic apply_list_request(input logic [plt_pkg::KIND_W-1:0] kind,
                                    input logic [plt_pkg::POS_W-1:0] position,
                                    input logic signed [plt_pkg::VAL_W-1:0] value);
    list_resp_t resp;
    int         pos;
    int         j;
    bit         hit;
    resp        = '0;
    resp.status = 1'b1;
    pos         = int'(position);
    hit         = 1'b0;
    case (kind)
      plt_pkg::KIND_READ: begin
        if (pos >= 1 && pos <= shadow_len) begin
          resp.read_value = shadow_list[pos-1];
          resp.status     = 1'b0;
        end
      end
      plt_pkg::KIND_LOCATE: begin
        for (j = 0; j < shadow_len; j++) begin
          if (!hit && shadow_list[j] == value) begin
            resp.found_position = plt_pkg::POS_W'(j + 1);
            resp.status         = 1'b0;
            hit                 = 1'b1;
          end
        end
      end
      plt_pkg::KIND_INSERT: begin
        if (pos >= 1 && pos <= shadow_len + 1 && shadow_len < CAPACITY) begin
          for (j = shadow_len; j >= pos; j--) shadow_list[j] = shadow_list[j-1];
          shadow_list[pos-1] = value;
          shadow_len++;
          resp.status = 1'b0;
        end else if (shadow_len == CAPACITY) begin
          full_rejects++;
        end
      end
      default: begin
        if (pos >= 1 && pos <= shadow_len) begin
          for (j = pos; j < shadow_len; j++) shadow_list[j-1] = shadow_list[j];
          shadow_len--;
          resp.status = 1'b0;
        end
      end
    endcase
    resp.list_length = plt_pkg::POS_W'(shadow_len);
    if (shadow_len > peak_len) peak_len = shadow_len;
    expected_resp.push_back(resp);
  endtask

  // Compare one accepted response against the oldest expectation
  task automatic check_list_response();
    list_resp_t want;
    if (expected_resp.size() == 0) begin
      report_mismatch("response arrived with no request outstanding");
    end else begin
      want = expected_resp.pop_front();
      checked++;
      if (status_i !== want.status)
        report_mismatch($sformatf("status: expected %0d got %0d", want.status, status_i));
      if (found_position_i !== want.found_position)
        report_mismatch($sformatf("found_position: expected %0d got %0d",
                                  want.found_position, found_position_i));
      if (read_value_i !== want.read_value)
        report_mismatch($sformatf("read_value: expected %0d got %0d",
                                  want.read_value, read_value_i));
      if (list_length_i !== want.list_length)
        report_mismatch($sformatf("list_length: expected %0d got %0d",
                                  want.list_length, list_length_i));
    end
  endtask

  // Watch both channels: retire responses first, then take in the new request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_len   = 0;
      expected_resp.delete();
      outstanding  = 0;
      mismatches   = 0;
      checked      = 0;
      peak_len     = 0;
      full_rejects = 0;
      for (int i = 0; i < CAPACITY; i++) shadow_list[i] = '0;
    end else begin
      if (out_valid_i && !out_stall_i) check_list_response();
      if (in_valid_i && !in_stall_i) apply_list_request(kind_i, position_i, value_i);
      outstanding = expected_resp.size();
    end
  end

endmodule

### bench/tb_positional_list_table.sv
// Testbench top for the positional list table: stimulus, flow control and verdict.
module tb_positional_list_table;

  localparam int unsigned CAPACITY     = 64;
  localparam int          RANDOM_ITEMS = 1700;
  localparam int          HOLD_AT      = 600;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 150;

  typedef enum int {PH_FILL, PH_MIX, PH_DRAIN} phase_e;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_valid   = 1'b0;
  logic                             in_stall;
  logic [plt_pkg::KIND_W-1:0]       kind       = plt_pkg::KIND_READ;
  logic [plt_pkg::POS_W-1:0]        position   = '0;
  logic signed [plt_pkg::VAL_W-1:0] value      = '0;
  logic                             out_valid;
  logic                             out_stall  = 1'b0;
  logic                             status;
  logic [plt_pkg::POS_W-1:0]        found_position;
  logic signed [plt_pkg::VAL_W-1:0] read_value;
  logic [plt_pkg::POS_W-1:0]        list_length;

  int errors;
  int outstanding;
  int checked;
  int peak_len;
  int full_rejects;

  int                               len_hint   = 0;
  int                               items_sent = 0;
  int                               burst_left = 0;
  int                               kind_count [4];
  logic signed [plt_pkg::VAL_W-1:0] value_pool [8];
  logic signed [plt_pkg::VAL_W-1:0] recent_vals [16];
  int                               recent_idx = 0;

  positional_list_table #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (plt_pkg::VAL_W)
  ) i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .kind_i           (kind),
    .position_i       (position),
    .value_i          (value),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .found_position_o (found_position),
    .read_value_o     (read_value),
    .list_length_o    (list_length)
  );

  plt_checker #(
    .CAPACITY (CAPACITY)
  ) i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .kind_i           (kind),
    .position_i       (position),
    .value_i          (value),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_i         (status),
    .found_position_i (found_position),
    .read_value_i     (read_value),
    .list_length_i    (list_length),
    .errors_o         (errors),
    .outstanding_o    (outstanding),
    .checked_o        (checked),
    .peak_length_o    (peak_len),
    .full_rejects_o   (full_rejects)
  );

  // Free-running clock, period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop if the run hangs
  initial begin
    #2_400_000;
    $display("tb_positional_list_table failed");
    $finish;
  end

  // Follow the list length from accepted responses to steer positions
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) len_hint <= int'(list_length);
  end

  // Offer one request, hold it until accepted, then maybe open a gap
  task automatic send_request(input logic [plt_pkg::KIND_W-1:0] k,
                              input logic [plt_pkg::POS_W-1:0] p,
                              input logic signed [plt_pkg::VAL_W-1:0] v);
    int gap;
    in_valid <= 1'b1;
    kind     <= k;
    position <= p;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    kind_count[k]++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap        = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mix of fully random, extreme and repeated values
  function automatic logic signed [plt_pkg::VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return value_pool[$urandom_range(0, 7)];
    if (r == 3) begin
      case ($urandom_range(0, 4))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return -32'sd1;
        3: return 32'sd1;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  // Mostly legal positions, with boundaries and some noise
  function automatic logic [plt_pkg::POS_W-1:0] pick_position(input int upper);
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return plt_pkg::POS_W'($urandom_range(0, 127));
    if (r == 2) return plt_pkg::POS_W'(1);
    if (r == 3) return plt_pkg::POS_W'(upper);
    if (r == 4) return plt_pkg::POS_W'(upper + 1);
    if (upper < 1) return plt_pkg::POS_W'(1);
    return plt_pkg::POS_W'($urandom_range(1, upper));
  endfunction

  // Build one random request weighted by the current phase
  task automatic random_request(input phase_e phase);
    int                               r;
    logic [plt_pkg::KIND_W-1:0]       k;
    logic [plt_pkg::POS_W-1:0]        p;
    logic signed [plt_pkg::VAL_W-1:0] v;
    r = $urandom_range(0, 99);
    case (phase)
      PH_FILL:  k = (r < 75) ? plt_pkg::KIND_INSERT :
                    (r < 87) ? plt_pkg::KIND_READ :
                    (r < 95) ? plt_pkg::KIND_LOCATE : plt_pkg::KIND_DELETE;
      PH_DRAIN: k = (r < 65) ? plt_pkg::KIND_DELETE :
                    (r < 80) ? plt_pkg::KIND_READ :
                    (r < 92) ? plt_pkg::KIND_LOCATE : plt_pkg::KIND_INSERT;
      default:  k = plt_pkg::KIND_W'(r % 4);
    endcase
    case (k)
      plt_pkg::KIND_INSERT: begin
        p = pick_position(len_hint + 1);
        v = pick_value();
        recent_vals[recent_idx] = v;
        recent_idx = (recent_idx + 1) % 16;
      end
      plt_pkg::KIND_LOCATE: begin
        p = plt_pkg::POS_W'($urandom_range(0, 127));
        v = ($urandom_range(0, 9) < 6) ? recent_vals[$urandom_range(0, 15)] : pick_value();
      end
      default: begin
        p = pick_position(len_hint);
        v = $urandom;
      end
    endcase
    // Refresh the repeat pool now and then
    if ($urandom_range(0, 49) == 0) value_pool[$urandom_range(0, 7)] = $urandom;
    send_request(k, p, v);
  endtask

  // Receiver: stall in random segments, with one long hold-off
  initial begin : receiver
    int  seg_len;
    int  mode;
    bit  hold_done;
    hold_done = 1'b0;
    wait (rst_n == 1'b1);
    @(posedge clk);
    forever begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(5, 60);
      repeat (seg_len) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
        @(posedge clk);
      end
    end
  end

  // Sender: reset, directed requests, random phases, drain and verdict
  initial begin : sender
    int     n;
    int     wait_cycles;
    phase_e phase;
    for (int i = 0; i < 4; i++) kind_count[i] = 0;
    for (int i = 0; i < 8; i++) value_pool[i] = $urandom;
    for (int i = 0; i < 16; i++) recent_vals[i] = $urandom;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list errors, bad positions, extremes, middle delete
    send_request(plt_pkg::KIND_READ,   7'd1,   32'sd7);
    send_request(plt_pkg::KIND_LOCATE, 7'd0,   32'sd0);
    send_request(plt_pkg::KIND_DELETE, 7'd1,   32'sd0);
    send_request(plt_pkg::KIND_INSERT, 7'd0,   32'sd5);
    send_request(plt_pkg::KIND_INSERT, 7'd2,   32'sd5);
    send_request(plt_pkg::KIND_INSERT, 7'd1,   32'sh8000_0000);
    send_request(plt_pkg::KIND_INSERT, 7'd2,   32'sh7fff_ffff);
    send_request(plt_pkg::KIND_INSERT, 7'd1,   32'sd0);
    send_request(plt_pkg::KIND_INSERT, 7'd4,   -32'sd1);
    send_request(plt_pkg::KIND_READ,   7'd1,   32'sd0);
    send_request(plt_pkg::KIND_READ,   7'd2,   32'sd0);
    send_request(plt_pkg::KIND_READ,   7'd3,   32'sd0);
    send_request(plt_pkg::KIND_READ,   7'd4,   32'sd0);
    send_request(plt_pkg::KIND_READ,   7'd5,   32'sd0);
    send_request(plt_pkg::KIND_READ,   7'd127, 32'sd0);
    send_request(plt_pkg::KIND_READ,   7'd0,   32'sd0);
    send_request(plt_pkg::KIND_LOCATE, 7'd127, 32'sh7fff_ffff);
    send_request(plt_pkg::KIND_LOCATE, 7'd0,   -32'sd1);
    send_request(plt_pkg::KIND_LOCATE, 7'd0,   32'sd12345);
    send_request(plt_pkg::KIND_INSERT, 7'd127, 32'sd9);
    send_request(plt_pkg::KIND_DELETE, 7'd2,   32'sd0);
    send_request(plt_pkg::KIND_DELETE, 7'd127, 32'sd0);
    send_request(plt_pkg::KIND_DELETE, 7'd0,   32'sd0);
    send_request(plt_pkg::KIND_LOCATE, 7'd64,  32'sd0);

    // Random: rounds of fill, mixed traffic and drain
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if ((n % 370) < 140)      phase = PH_FILL;
      else if ((n % 370) < 240) phase = PH_MIX;
      else                      phase = PH_DRAIN;
      random_request(phase);
    end
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end

    // Drain outstanding responses, then let the block settle
    while (outstanding != 0) @(posedge clk);
    wait_cycles = DRAIN_CYCLES;
    repeat (wait_cycles) @(posedge clk);

    $display("Summary: %0d requests (read %0d, locate %0d, insert %0d, delete %0d), %0d checked",
             items_sent, kind_count[plt_pkg::KIND_READ], kind_count[plt_pkg::KIND_LOCATE],
             kind_count[plt_pkg::KIND_INSERT], kind_count[plt_pkg::KIND_DELETE], checked);
    $display("Summary: peak length %0d of %0d, %0d inserts refused on a full list, %0d errors",
             peak_len, CAPACITY, full_rejects, errors);
    if (errors == 0) $display("tb_positional_list_table passed");
    else $display("tb_positional_list_table failed");
    $finish;
  end

endmodule
